[rtl/core/trca_pkg.sv]
// ----------------------------------------------------------------------------
// trca_pkg
// Shared codes, constants and pipeline stage types of the reduction ALU.
// ----------------------------------------------------------------------------
package trca_pkg;

   // reduction operation codes
   localparam logic [3:0] OP_MAX  = 4'd0;
   localparam logic [3:0] OP_MIN  = 4'd1;
   localparam logic [3:0] OP_SUM  = 4'd2;
   localparam logic [3:0] OP_PROD = 4'd3;
   localparam logic [3:0] OP_LAND = 4'd4;
   localparam logic [3:0] OP_LOR  = 4'd5;
   localparam logic [3:0] OP_LXOR = 4'd6;
   localparam logic [3:0] OP_BAND = 4'd7;
   localparam logic [3:0] OP_BOR  = 4'd8;
   localparam logic [3:0] OP_BXOR = 4'd9;

   // element type codes
   localparam logic [3:0] DT_S8   = 4'd0;
   localparam logic [3:0] DT_S16  = 4'd1;
   localparam logic [3:0] DT_S32L = 4'd2;
   localparam logic [3:0] DT_S32  = 4'd3;
   localparam logic [3:0] DT_U8   = 4'd4;
   localparam logic [3:0] DT_U16  = 4'd5;
   localparam logic [3:0] DT_U32  = 4'd6;
   localparam logic [3:0] DT_U32L = 4'd7;
   localparam logic [3:0] DT_F32  = 4'd8;
   localparam logic [3:0] DT_F64  = 4'd9;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_OP   = 2'd1;
   localparam logic [1:0] ST_BAD_TYPE = 2'd2;

   // register indexes
   localparam logic [7:0] REG_REDUCE_OP = 8'd0;
   localparam logic [7:0] REG_DATA_TYPE = 8'd1;

   localparam logic [3:0] RESET_REDUCE_OP = OP_SUM;
   localparam logic [3:0] RESET_DATA_TYPE = DT_S32;

   // wide significand of the float datapath
   localparam int unsigned WIDE_W = 106;

   typedef struct packed {
      logic              sign;
      logic signed [12:0] expo;
      logic [52:0]       mant;
      logic [62:0]       mag;
      logic              is_nan;
      logic              is_inf;
      logic              is_zero;
   } fp_unp_type;

   typedef struct packed {
      logic        last;
      logic [1:0]  status;
      logic        bypass;
      logic [63:0] byp_val;
      logic        is_f64;
      logic        sign;
      logic        zero_sign;
   } ctl_type;

   typedef struct packed {
      ctl_type            ctl;
      logic               is_mul;
      logic [52:0]        x_m;
      logic [52:0]        y_m;
      logic [5:0]         shift_dist;
      logic               eff_sub;
      logic signed [12:0] t;
      logic [51:0]        pp_hh;
      logic [52:0]        pp_hl;
      logic [52:0]        pp_lh;
      logic [53:0]        pp_ll;
   } s1_type;

   typedef struct packed {
      ctl_type            ctl;
      logic signed [12:0] t;
      logic [WIDE_W-1:0]  w;
   } s2_type;

   typedef struct packed {
      ctl_type            ctl;
      logic signed [12:0] t;
      logic [WIDE_W-1:0]  w;
      logic [6:0]         lz;
      logic               wzero;
   } s3_type;

   typedef struct packed {
      ctl_type            ctl;
      logic signed [12:0] ue;
      logic [WIDE_W-1:0]  w;
      logic               wzero;
   } s4_type;

   typedef struct packed {
      ctl_type           ctl;
      logic [11:0]       efield;
      logic [WIDE_W-1:0] w;
      logic              wzero;
   } s5_type;

endpackage

[rtl/core/typed_reduction_combine_alu_core.sv]
// ----------------------------------------------------------------------------
// typed_reduction_combine_alu_core
// Combines an incoming element with an accumulated element under the
// configured reduction operation and element type.
// ----------------------------------------------------------------------------
// Six-stage pipeline: one transaction is accepted every cycle when the result
// side keeps taking them. Stage one decodes, finishes all integer, compare,
// logical and special-value cases and forms the partial products of the
// 26- and 27-bit significand pieces of the float multiply; stage two adds the
// aligned significands or sums the partial products; stage three counts
// leading zeros; stage four normalizes; stage five handles subnormal results;
// stage six rounds to nearest even and packs. Each stage holds its transaction
// while the one after it is full and cannot advance, so a stalled result side
// only fills the bubbles ahead of it. Write reduce_op and data_type only while
// no transaction is in flight.
module typed_reduction_combine_alu_core import trca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_incoming_value,
   input  logic [63:0] req_accumulated_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_combined_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [3:0]  csr_data
);

   logic [3:0] reduce_op_ff, reduce_op_in;
   logic [3:0] data_type_ff, data_type_in;

   // stage valid bits and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   logic [63:0] res_in, res_ff;
   logic [1:0]  stat_ff;
   logic        last_ff;

   logic signed [12:0] emin, shamt;
   logic [6:0]         sh7;
   logic [WIDE_W-1:0]  wsh;

   // configuration: always ready, write on handshake
   assign csr_ready = 1'b1;

   always_comb begin
      reduce_op_in = reduce_op_ff;
      data_type_in = data_type_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == REG_REDUCE_OP) reduce_op_in = csr_data;
         if (csr_index == REG_DATA_TYPE) data_type_in = csr_data;
      end
   end

   // advance a stage when the stage after it is empty or advancing
   assign en6       = !v6_ff || rsp_ready;
   assign en5       = !v5_ff || en6;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   trca_decode u_decode (
      .reduce_op (reduce_op_ff),
      .data_type (data_type_ff),
      .a_val     (req_incoming_value),
      .b_val     (req_accumulated_value),
      .last      (req_last_element),
      .s1        (s1_in)
   );

   trca_fp_merge u_merge (
      .s1 (s1_ff),
      .s2 (s2_in)
   );

   trca_fp_lzc u_lzc (
      .s2 (s2_ff),
      .s3 (s3_in)
   );

   // stage four: normalize to the top bit
   always_comb begin
      s4_in.ctl   = s3_ff.ctl;
      s4_in.w     = s3_ff.w << s3_ff.lz;
      s4_in.ue    = s3_ff.t - $signed({6'd0, s3_ff.lz});
      s4_in.wzero = s3_ff.wzero;
   end

   // stage five: shift subnormal results right, fold lost bits into sticky
   always_comb begin
      emin  = s4_ff.ctl.is_f64 ? -13'sd1022 : -13'sd126;
      shamt = emin - s4_ff.ue;
      sh7   = (shamt > 13'sd127) ? 7'd127 : shamt[6:0];
      wsh   = s4_ff.w >> sh7;
      s5_in.ctl   = s4_ff.ctl;
      s5_in.wzero = s4_ff.wzero;
      if (s4_ff.ue < emin) begin
         s5_in.w      = wsh | {{(WIDE_W-1){1'b0}}, ((wsh << sh7) != s4_ff.w)};
         s5_in.efield = 12'd0;
      end else begin
         s5_in.w      = s4_ff.w;
         s5_in.efield = 12'(s4_ff.ue + (s4_ff.ctl.is_f64 ? 13'sd1022 : 13'sd126));
      end
   end

   trca_fp_round u_round (
      .s5     (s5_ff),
      .result (res_in)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reduce_op_ff <= RESET_REDUCE_OP;
         data_type_ff <= RESET_DATA_TYPE;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         reduce_op_ff <= reduce_op_in;
         data_type_ff <= data_type_in;
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // payload registers: hold while stalled
   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) s4_ff <= s4_in;
      if (en5) s5_ff <= s5_in;
      if (en6) begin
         res_ff  <= res_in;
         stat_ff <= s5_ff.ctl.status;
         last_ff <= s5_ff.ctl.last;
      end
   end

   assign rsp_valid          = v6_ff;
   assign rsp_combined_value = res_ff;
   assign rsp_status         = stat_ff;
   assign rsp_last_out       = last_ff;

`ifndef SYNTHESIS
   // a delivered status is one of the three defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("undefined status code delivered");

   // input backpressure only when every stage is full and the output stalls
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff && !rsp_ready))
      else $error("input stalled with room in the pipeline");

   // a transaction leaving stage one lands in stage two
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && en2) |=> v2_ff)
      else $error("transaction lost between stage one and two");

   // a held result stays valid with the same value
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_combined_value)))
      else $error("stalled result changed");
`endif

endmodule

[rtl/core/trca_decode.sv]
// ----------------------------------------------------------------------------
// trca_decode
// First stage: integer and compare results, float specials, add alignment
// setup and the multiplier's partial products.
// ----------------------------------------------------------------------------
module trca_decode import trca_pkg::*; (
   input  logic [3:0]  reduce_op,
   input  logic [3:0]  data_type,
   input  logic [63:0] a_val,
   input  logic [63:0] b_val,
   input  logic        last,
   output s1_type      s1
);

   function automatic fp_unp_type unpack(input logic [63:0] v, input logic f64);
      fp_unp_type u;
      if (f64) begin
         u.sign    = v[63];
         u.expo    = (v[62:52] == 11'd0) ? -13'sd1022
                                         : $signed({2'b0, v[62:52]}) - 13'sd1023;
         u.mant    = {(v[62:52] != 11'd0), v[51:0]};
         u.mag     = v[62:0];
         u.is_nan  = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
         u.is_inf  = (v[62:52] == 11'h7FF) && (v[51:0] == 52'd0);
      end else begin
         u.sign    = v[31];
         u.expo    = (v[30:23] == 8'd0) ? -13'sd126
                                       : $signed({5'b0, v[30:23]}) - 13'sd127;
         u.mant    = {(v[30:23] != 8'd0), v[22:0], 29'd0};
         u.mag     = {32'd0, v[30:0]};
         u.is_nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
         u.is_inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
      end
      u.is_zero = (u.mag == 63'd0);
      return u;
   endfunction

   function automatic logic flt_lt(input fp_unp_type x, input fp_unp_type y);
      logic r;
      if (x.is_nan || y.is_nan || (x.is_zero && y.is_zero)) begin
         r = 1'b0;
      end else if (x.sign != y.sign) begin
         r = x.sign;
      end else if (!x.sign) begin
         r = x.mag < y.mag;
      end else begin
         r = x.mag > y.mag;
      end
      return r;
   endfunction

   logic [63:0] mask, sbit, am, bm, ka, kb, prod, ires;
   logic        sgn, is_int, is_flt, f64;
   logic [1:0]  istat;
   fp_unp_type  ua, ub, ux, uy;
   logic [63:0] fa, fb, one_v, qnan_bit, dnan, fres;
   logic        arith, a_big, nza, nzb;
   logic [1:0]  fstat;
   logic signed [12:0] ediff;

   always_comb begin
      mask   = 64'h0;
      sbit   = 64'h0;
      sgn    = 1'b0;
      is_int = 1'b1;
      is_flt = 1'b0;
      f64    = 1'b0;
      unique case (data_type)
         DT_S8:            begin mask = 64'hFF;       sbit = 64'h80;       sgn = 1'b1; end
         DT_S16:           begin mask = 64'hFFFF;     sbit = 64'h8000;     sgn = 1'b1; end
         DT_S32L, DT_S32:  begin mask = 64'hFFFF_FFFF; sbit = 64'h8000_0000; sgn = 1'b1; end
         DT_U8:            begin mask = 64'hFF;       sbit = 64'h80;       end
         DT_U16:           begin mask = 64'hFFFF;     sbit = 64'h8000;     end
         DT_U32, DT_U32L:  begin mask = 64'hFFFF_FFFF; sbit = 64'h8000_0000; end
         DT_F32:           begin is_int = 1'b0; is_flt = 1'b1; end
         DT_F64:           begin is_int = 1'b0; is_flt = 1'b1; f64 = 1'b1; end
         default:          begin is_int = 1'b0; end
      endcase

      // integer path
      am   = a_val & mask;
      bm   = b_val & mask;
      ka   = sgn ? (am ^ sbit) : am;
      kb   = sgn ? (bm ^ sbit) : bm;
      prod = am[31:0] * bm[31:0];
      istat = ST_OK;
      case (reduce_op)
         OP_MAX:  ires = (ka < kb) ? bm : am;
         OP_MIN:  ires = (kb < ka) ? bm : am;
         OP_SUM:  ires = am + bm;
         OP_PROD: ires = prod;
         OP_LAND: ires = {63'd0, (am != 64'd0) && (bm != 64'd0)};
         OP_LOR:  ires = {63'd0, (am != 64'd0) || (bm != 64'd0)};
         OP_LXOR: ires = {63'd0, (am != 64'd0) != (bm != 64'd0)};
         OP_BAND: ires = am & bm;
         OP_BOR:  ires = am | bm;
         OP_BXOR: ires = am ^ bm;
         default: begin ires = bm; istat = ST_BAD_OP; end
      endcase
      ires = ires & mask;

      // float path
      ua       = unpack(a_val, f64);
      ub       = unpack(b_val, f64);
      fa       = f64 ? a_val : {32'd0, a_val[31:0]};
      fb       = f64 ? b_val : {32'd0, b_val[31:0]};
      one_v    = f64 ? 64'h3FF0_0000_0000_0000 : 64'h0000_0000_3F80_0000;
      qnan_bit = f64 ? 64'h0008_0000_0000_0000 : 64'h0000_0000_0040_0000;
      dnan     = f64 ? 64'hFFF8_0000_0000_0000 : 64'h0000_0000_FFC0_0000;
      nza      = !ua.is_zero;
      nzb      = !ub.is_zero;
      arith    = 1'b0;
      fstat    = ST_OK;
      fres     = fb;
      case (reduce_op)
         OP_MAX:  fres = flt_lt(ua, ub) ? fb : fa;
         OP_MIN:  fres = flt_lt(ub, ua) ? fb : fa;
         OP_LAND: fres = (nza && nzb) ? one_v : 64'd0;
         OP_LOR:  fres = (nza || nzb) ? one_v : 64'd0;
         OP_LXOR: fres = (nza != nzb) ? one_v : 64'd0;
         OP_SUM: begin
            if (ua.is_nan)                                          fres = fa | qnan_bit;
            else if (ub.is_nan)                                     fres = fb | qnan_bit;
            else if (ua.is_inf && ub.is_inf && (ua.sign != ub.sign)) fres = dnan;
            else if (ua.is_inf)                                     fres = fa;
            else if (ub.is_inf)                                     fres = fb;
            else                                                    arith = 1'b1;
         end
         OP_PROD: begin
            if (ua.is_nan)      fres = fa | qnan_bit;
            else if (ub.is_nan) fres = fb | qnan_bit;
            else if ((ua.is_inf && ub.is_zero) || (ua.is_zero && ub.is_inf)) fres = dnan;
            else if (ua.is_inf || ub.is_inf) begin
               fres = f64 ? {ua.sign ^ ub.sign, 11'h7FF, 52'd0}
                          : {32'd0, ua.sign ^ ub.sign, 8'hFF, 23'd0};
            end else begin
               arith = 1'b1;
            end
         end
         default: begin fres = fb; fstat = ST_BAD_OP; end
      endcase

      // add alignment: larger magnitude first
      a_big = (ua.expo > ub.expo) || ((ua.expo == ub.expo) && (ua.mant >= ub.mant));
      ux    = a_big ? ua : ub;
      uy    = a_big ? ub : ua;
      ediff = ux.expo - uy.expo;

      s1.is_mul     = (reduce_op == OP_PROD);
      s1.x_m        = ux.mant;
      s1.y_m        = uy.mant;
      s1.shift_dist = (ediff > 13'sd63) ? 6'd63 : ediff[5:0];
      s1.eff_sub    = ua.sign ^ ub.sign;
      s1.t          = s1.is_mul ? (ua.expo + ub.expo + 13'sd1) : (ux.expo + 13'sd1);
      s1.pp_hh      = ua.mant[52:27] * ub.mant[52:27];
      s1.pp_hl      = ua.mant[52:27] * ub.mant[26:0];
      s1.pp_lh      = ua.mant[26:0] * ub.mant[52:27];
      s1.pp_ll      = ua.mant[26:0] * ub.mant[26:0];

      s1.ctl.last      = last;
      s1.ctl.is_f64    = f64;
      s1.ctl.sign      = s1.is_mul ? (ua.sign ^ ub.sign) : ux.sign;
      s1.ctl.zero_sign = s1.is_mul ? (ua.sign ^ ub.sign)
                                   : (s1.eff_sub ? 1'b0 : ua.sign);
      if (is_int) begin
         s1.ctl.bypass  = 1'b1;
         s1.ctl.byp_val = ires;
         s1.ctl.status  = istat;
      end else if (is_flt) begin
         s1.ctl.bypass  = !arith;
         s1.ctl.byp_val = fres;
         s1.ctl.status  = fstat;
      end else begin
         s1.ctl.bypass  = 1'b1;
         s1.ctl.byp_val = b_val;
         s1.ctl.status  = ST_BAD_TYPE;
      end
   end

endmodule

[rtl/core/trca_fp_merge.sv]
// ----------------------------------------------------------------------------
// trca_fp_merge
// Second stage: aligned significand add or subtract, partial product sum.
// ----------------------------------------------------------------------------
module trca_fp_merge import trca_pkg::*; (
   input  s1_type s1,
   output s2_type s2
);

   logic [55:0] x56, y56, ys_full, ys;
   logic        lost;
   logic [56:0] sum57;
   logic [WIDE_W-1:0] prod;

   always_comb begin
      x56     = {s1.x_m, 3'd0};
      y56     = {s1.y_m, 3'd0};
      ys_full = y56 >> s1.shift_dist;
      lost    = ((ys_full << s1.shift_dist) != y56);
      ys      = ys_full | {55'd0, lost};
      sum57   = s1.eff_sub ? ({1'b0, x56} - {1'b0, ys}) : ({1'b0, x56} + {1'b0, ys});
      prod    = {s1.pp_hh, 54'd0}
              + WIDE_W'({(54'(s1.pp_hl) + 54'(s1.pp_lh)), 27'd0})
              + WIDE_W'(s1.pp_ll);
      s2.ctl  = s1.ctl;
      s2.t    = s1.t;
      s2.w    = s1.is_mul ? prod : {sum57, 49'd0};
   end

endmodule

[rtl/core/trca_fp_lzc.sv]
// ----------------------------------------------------------------------------
// trca_fp_lzc
// Third stage: leading zero count of the wide significand.
// ----------------------------------------------------------------------------
module trca_fp_lzc import trca_pkg::*; (
   input  s2_type s2,
   output s3_type s3
);

   always_comb begin
      s3.ctl   = s2.ctl;
      s3.t     = s2.t;
      s3.w     = s2.w;
      s3.wzero = (s2.w == '0);
      s3.lz    = 7'd0;
      for (int i = 0; i < WIDE_W; i++) begin
         if (s2.w[i]) begin
            s3.lz = 7'(WIDE_W - 1 - i);
         end
      end
   end

endmodule

[rtl/core/trca_fp_round.sv]
// ----------------------------------------------------------------------------
// trca_fp_round
// Last stage: round to nearest even, pack, overflow to infinity, and
// final selection of the bypassed result.
// ----------------------------------------------------------------------------
module trca_fp_round import trca_pkg::*; (
   input  s5_type      s5,
   output logic [63:0] result
);

   logic [52:0] m64;
   logic [53:0] m64_r;
   logic [63:0] pack64;
   logic [23:0] m32;
   logic [24:0] m32_r;
   logic [34:0] pack32;
   logic        inc64, inc32;

   always_comb begin
      inc64  = s5.w[52] & ((|s5.w[51:0]) | s5.w[53]);
      m64    = s5.w[105:53];
      m64_r  = {1'b0, m64} + {53'd0, inc64};
      pack64 = {s5.efield, 52'd0} + {10'd0, m64_r};

      inc32  = s5.w[81] & ((|s5.w[80:0]) | s5.w[82]);
      m32    = s5.w[105:82];
      m32_r  = {1'b0, m32} + {24'd0, inc32};
      pack32 = {s5.efield, 23'd0} + {10'd0, m32_r};

      if (s5.ctl.bypass) begin
         result = s5.ctl.byp_val;
      end else if (s5.ctl.is_f64) begin
         if (s5.wzero) begin
            result = {s5.ctl.zero_sign, 63'd0};
         end else if (pack64[63:52] >= 12'd2047) begin
            result = {s5.ctl.sign, 11'h7FF, 52'd0};
         end else begin
            result = {s5.ctl.sign, pack64[62:0]};
         end
      end else begin
         if (s5.wzero) begin
            result = {32'd0, s5.ctl.zero_sign, 31'd0};
         end else if (pack32[34:23] >= 12'd255) begin
            result = {32'd0, s5.ctl.sign, 8'hFF, 23'd0};
         end else begin
            result = {32'd0, s5.ctl.sign, pack32[30:0]};
         end
      end
   end

endmodule
